### rtl/core/gng_pkg.sv
package gng_pkg;

    localparam int SEED_W     = 20;
    localparam int SIGMA_W    = 24;
    localparam int MEAN_W     = 32;
    localparam int SUM_W      = 24;
    localparam int X_W        = 24;
    localparam int PROD_W     = X_W + SIGMA_W + 1;
    localparam int FRAC_SHIFT = 20;
    localparam int Y_W        = MEAN_W + 2;
    localparam int TERM_W     = PROD_W - FRAC_SHIFT;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int SUM_TERMS  = 12;
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0]      LAST_TERM   = CNT_W'(SUM_TERMS - 1);
    localparam logic [X_W:0]          LCG_MULT    = (X_W + 1)'(2045);
    localparam logic [SUM_W-1:0]      X_OFFSET    = SUM_W'(SUM_TERMS * (1 << (SEED_W - 1)));
    localparam logic [SIGMA_W-1:0]    SIGMA_RESET = SIGMA_W'(6554);
    localparam logic [SEED_W-1:0]     SEED_RESET  = SEED_W'(1);

    localparam logic [CFG_IDX_W-1:0]  REG_SIGMA      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  REG_SEED_START = CFG_IDX_W'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_FIN  = 5'b00100,
        S_MUL  = 5'b01000,
        S_RND  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic first;
        logic finish;
        logic mul;
        logic rnd;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/gng_ctrl.sv
module gng_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gng_pkg::t_dp_sts i_sts,
    output gng_pkg::t_dp_cmd o_cmd
);

    gng_pkg::t_state                r_state, n_state;
    logic [gng_pkg::CNT_W-1:0]      r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            gng_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = gng_pkg::S_STEP;
                end
            end
            gng_pkg::S_STEP: begin
                o_cmd.step  = 1'b1;
                o_cmd.first = (r_cnt == '0);
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == gng_pkg::LAST_TERM) begin
                    n_state = gng_pkg::S_FIN;
                end
            end
            gng_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = gng_pkg::S_MUL;
            end
            gng_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = gng_pkg::S_RND;
            end
            gng_pkg::S_RND: begin
                if (i_sts.out_free) begin
                    o_cmd.rnd = 1'b1;
                    n_state   = gng_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gng_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != gng_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gng_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### rtl/core/gng_dp.sv
module gng_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gng_pkg::t_dp_cmd                     i_cmd,
    output gng_pkg::t_dp_sts                     o_sts,
    input  logic                                 i_cfg_we,
    input  logic [gng_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gng_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [gng_pkg::MEAN_W-1:0]    i_mean,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [gng_pkg::MEAN_W-1:0]    o_sample,
    output logic                                 o_saturated
);

    logic [gng_pkg::SIGMA_W-1:0]            r_sigma;
    logic [gng_pkg::SEED_W-1:0]             r_seed;
    logic [gng_pkg::SUM_W-1:0]              r_sum;
    logic signed [gng_pkg::X_W-1:0]         r_x;
    logic signed [gng_pkg::PROD_W-1:0]      r_prod;
    logic signed [gng_pkg::MEAN_W-1:0]      r_mean;
    logic signed [gng_pkg::MEAN_W-1:0]      r_sample;
    logic                                   r_sat;
    logic                                   r_out_vld;

    logic signed [gng_pkg::X_W:0]           mul_a;
    logic signed [gng_pkg::X_W:0]           mul_b;
    logic signed [2*gng_pkg::X_W+1:0]       mul_p;
    logic [gng_pkg::SEED_W-1:0]             seed_next;
    logic [gng_pkg::SUM_W-1:0]              sum_all;
    logic signed [gng_pkg::TERM_W-1:0]      term;
    logic signed [gng_pkg::Y_W-1:0]         y;
    logic                                   y_hi;
    logic                                   y_lo;

    // The multiplier serves the generator steps and the final scaling.
    always_comb begin
        if (i_cmd.mul) begin
            mul_a = {r_x[gng_pkg::X_W-1], r_x};
            mul_b = {1'b0, r_sigma};
        end else begin
            mul_a = {{(gng_pkg::X_W + 1 - gng_pkg::SEED_W){1'b0}}, r_seed};
            mul_b = gng_pkg::LCG_MULT;
        end
    end

    assign mul_p     = mul_a * mul_b;
    assign seed_next = mul_p[gng_pkg::SEED_W-1:0] + gng_pkg::SEED_W'(1);
    assign sum_all   = r_sum + gng_pkg::SUM_W'(r_seed);

    // Rounding to nearest is folded into the mean addition as a carry in.
    assign term = r_prod[gng_pkg::PROD_W-1:gng_pkg::FRAC_SHIFT];
    assign y    = gng_pkg::Y_W'(r_mean) + gng_pkg::Y_W'(term)
                + gng_pkg::Y_W'(r_prod[gng_pkg::FRAC_SHIFT-1]);
    assign y_hi = !y[gng_pkg::Y_W-1] && (y[gng_pkg::Y_W-2:gng_pkg::MEAN_W-1] != '0);
    assign y_lo = y[gng_pkg::Y_W-1] && (y[gng_pkg::Y_W-2:gng_pkg::MEAN_W-1] != '1);

    assign o_sts.out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma   <= gng_pkg::SIGMA_RESET;
            r_seed    <= gng_pkg::SEED_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == gng_pkg::REG_SIGMA)) begin
                r_sigma <= i_cfg_data[gng_pkg::SIGMA_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == gng_pkg::REG_SEED_START)) begin
                r_seed <= i_cfg_data[gng_pkg::SEED_W-1:0];
            end else if (i_cmd.step) begin
                r_seed <= seed_next;
            end
            if (i_cmd.rnd) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mean <= i_mean;
        end
        if (i_cmd.step) begin
            r_sum <= i_cmd.first ? '0 : sum_all;
        end
        if (i_cmd.finish) begin
            r_x <= signed'(sum_all - gng_pkg::X_OFFSET);
        end
        if (i_cmd.mul) begin
            r_prod <= mul_p[gng_pkg::PROD_W-1:0];
        end
        if (i_cmd.rnd) begin
            r_sat <= y_hi || y_lo;
            if (y_hi) begin
                r_sample <= {1'b0, {(gng_pkg::MEAN_W-1){1'b1}}};
            end else if (y_lo) begin
                r_sample <= {1'b1, {(gng_pkg::MEAN_W-1){1'b0}}};
            end else begin
                r_sample <= y[gng_pkg::MEAN_W-1:0];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_sample    = r_sample;
    assign o_saturated = r_sat;

endmodule

### rtl/core/gaussian_noise_generator_unit.sv
// Each request runs through twelve generator steps, the offset subtraction, the scaling
// and the rounding; one shared multiplier serves the generator steps and the scaling.
// No new request is taken while one is in progress; the rounding waits for a free output.
// A new request is taken while the previous result still waits at the output.
// Synchronous active-low reset sets sigma to 6554 and the seed to 1.
module gaussian_noise_generator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gng_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gng_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [gng_pkg::MEAN_W-1:0]    i_mean,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [gng_pkg::MEAN_W-1:0]    o_sample,
    output logic                                 o_saturated
);

    gng_pkg::t_dp_cmd cmd;
    gng_pkg::t_dp_sts sts;

    gng_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gng_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mean      (i_mean),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .o_saturated (o_saturated)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int                   HALF_PERIOD  = 10;
    localparam int                   QUIET_LIMIT  = 2000;
    localparam int                   IDLE_PERCENT = 13;
    localparam int                   HOLD_CYCLES  = 20;
    localparam int                   PHASE_COUNT  = 8;
    localparam int                   PHASE_ITEMS  = 66;
    localparam int                   CALM_PHASE   = 4;
    localparam logic [19:0]          GEN_MULT     = 20'd2045;
    localparam longint               GEN_OFFSET   = 64'sd6 * 64'sd1048576;
    localparam int                   IDX_W        = gng_pkg::CFG_IDX_W;
    localparam int                   DATA_W       = gng_pkg::CFG_DATA_W;
    localparam int                   M_W          = gng_pkg::MEAN_W;
    localparam logic [IDX_W-1:0]     REG_SIGMA      = gng_pkg::REG_SIGMA;
    localparam logic [IDX_W-1:0]     REG_SEED_START = gng_pkg::REG_SEED_START;
    localparam logic [IDX_W-1:0]     REG_SPARE_A  = IDX_W'(2);
    localparam logic [IDX_W-1:0]     REG_SPARE_B  = IDX_W'(3);

    typedef enum logic {ROW_REQUEST, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [IDX_W-1:0]       index;
        logic [DATA_W-1:0]      data;
        logic [M_W-1:0]         mean;
        logic                   typed;
        logic [M_W-1:0]         want_sample;
        logic                   want_sat;
    } t_plan_row;

    typedef struct packed {
        logic [M_W-1:0]    sample;
        logic              sat;
    } t_noise_result;

    localparam int PLAN_LEN = 28;
    localparam t_plan_row PLAN [0:PLAN_LEN-1] = '{
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h7FFFFFFF, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h80000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h00010000, 1'b0, 32'h0,        1'b0},
        '{ROW_WRITE,   REG_SIGMA,      24'h000000, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h80000000, 1'b1, 32'h80000000, 1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5, 1'b0},
        '{ROW_WRITE,   REG_SIGMA,      24'hFFFFFF, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h7FFFFFFF, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h80000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h7FFFFFFF, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h80000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h7FFFFFFF, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h80000000, 1'b0, 32'h0,        1'b0},
        '{ROW_WRITE,   REG_SEED_START, 24'h000000, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h7FFFFFFF, 1'b0, 32'h0,        1'b0},
        '{ROW_WRITE,   REG_SEED_START, 24'hFFFFFF, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h80000000, 1'b0, 32'h0,        1'b0},
        '{ROW_WRITE,   REG_SPARE_A,    24'h000000, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_WRITE,   REG_SPARE_B,    24'h123456, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h7FFFFFFF, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h80000000, 1'b0, 32'h0,        1'b0},
        '{ROW_WRITE,   REG_SIGMA,      24'h010000, 32'h00000000, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'h5A5A5A5A, 1'b0, 32'h0,        1'b0},
        '{ROW_REQUEST, REG_SIGMA,      24'h000000, 32'hFFFFFFFF, 1'b0, 32'h0,        1'b0}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [M_W-1:0]         in_mean   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [M_W-1:0]         out_sample;
    logic                   out_saturated;

    logic [gng_pkg::SIGMA_W-1:0] cur_sigma;
    logic [gng_pkg::SEED_W-1:0]  gen_seed;
    t_noise_result          pending_samples [$];
    int                     mismatches = 0;
    int                     quiet_cycles = 0;
    logic                   calm = 1'b0;

    gaussian_noise_generator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_mean      (in_mean),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_sample    (out_sample),
        .o_saturated (out_saturated)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic t_noise_result draw_sample(input logic [M_W-1:0] m);
        t_noise_result res;
        longint        sum;
        longint        term;
        longint        y;
        sum = 0;
        for (int i = 0; i < gng_pkg::SUM_TERMS; i++) begin
            gen_seed = gen_seed * GEN_MULT + 20'd1;
            sum += longint'(gen_seed);
        end
        term = ((sum - GEN_OFFSET) * longint'(cur_sigma) + 64'sd524288) >>> 20;
        y = $signed(m);
        y = y + term;
        res.sat = 1'b0;
        if (y > 64'sd2147483647) begin
            y = 64'sd2147483647;
            res.sat = 1'b1;
        end else if (y < -64'sd2147483648) begin
            y = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.sample = y[M_W-1:0];
        return res;
    endfunction

    function automatic logic [M_W-1:0] pick_mean();
        case ($urandom_range(0, 9))
            6, 7:    return 32'h7FFFFFFF - $urandom_range(0, 32'h0FFFFFFF);
            8, 9:    return 32'h80000000 + $urandom_range(0, 32'h0FFFFFFF);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained(input int hold);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (hold) @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] data);
        wait_drained(HOLD_CYCLES);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SIGMA:      cur_sigma = data[gng_pkg::SIGMA_W-1:0];
            REG_SEED_START: gen_seed  = data[gng_pkg::SEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [M_W-1:0] m, input logic typed,
                                input t_noise_result typed_res);
        t_noise_result res;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mean  <= m;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        res = draw_sample(m);
        if (typed)
            res = typed_res;
        pending_samples = {pending_samples, res};
    endtask

    always @(posedge clk) begin : result_check
        t_noise_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %h sat %b", out_sample, out_saturated);
            end else begin
                want = pending_samples.pop_front();
                if (out_sample !== want.sample || out_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: expected %h sat %b, got %h sat %b",
                                 want.sample, want.sat, out_sample, out_saturated);
                end
            end
        end
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_plan_row     row;
        t_noise_result typed_res;
        cur_sigma = gng_pkg::SIGMA_W'(6554);
        gen_seed  = gng_pkg::SEED_W'(1);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            row = PLAN[r];
            if (row.kind == ROW_WRITE) begin
                write_register(row.index, row.data);
            end else begin
                typed_res.sample = row.want_sample;
                typed_res.sat    = row.want_sat;
                send_request(row.mean, row.typed, typed_res);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0:       write_register(REG_SIGMA, 24'hFFFFFF);
                1:       write_register(REG_SIGMA, DATA_W'($urandom));
                2:       write_register(REG_SIGMA, DATA_W'($urandom_range(0, 24'h020000)));
                default: write_register(REG_SIGMA, 24'h000000);
            endcase
            if (p == 3)
                write_register(REG_SEED_START, 24'h0FFFFF);
            else
                write_register(REG_SEED_START, DATA_W'($urandom));
            if (p == 5)
                write_register($urandom_range(2, 3) == 2 ? REG_SPARE_A : REG_SPARE_B,
                               DATA_W'($urandom));
            calm = (p == CALM_PHASE);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == PHASE_ITEMS / 2)
                    wait_drained(0);
                send_request(pick_mean(), 1'b0, '0);
            end
            calm = 1'b0;
        end

        wait_drained(30);
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
